>>> rtl/nsr_pkg.sv
// Shared types, constants and codes of the Newton square root unit.
`default_nettype none

package nsr_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int TOL_W      = 32;
    localparam int LIMIT_W    = 6;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 32'd42950;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'd1;

    localparam logic [STATUS_W-1:0] STS_TOLERANCE = 2'd0;
    localparam logic [STATUS_W-1:0] STS_STALLED   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_LIMIT     = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CHECK,
        ST_DIVIDE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

endpackage

`default_nettype wire

>>> rtl/newton_square_root_unit.sv
// Newton square root unit: sequencer, estimate update, registers and result port.
//
// Command channel: a radicand (unsigned, FRAC_BITS fractional bits) transfers on a
// rising edge with start high and busy low. busy stays high until the result is out.
// Result channel: o_valid is high for exactly one cycle with o_root, o_steps_taken
// and o_finish_status; the receiver takes it in that cycle and cannot stall it.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx (0 tolerance,
// 1 iteration limit) on the edge. The user must write only while the unit is idle;
// the unit does not enforce this. A zero radicand answers zero in the next cycle.
// Otherwise each Newton step runs the serial squarer, the residual check and the
// restoring divider: the squarer takes one multiplier bit per cycle and the divider
// one quotient bit per cycle, or none when its up-front check finds the quotient
// overflows. A step that leaves the estimate unchanged ends the item with no closing
// square and residual check.
// One item is in work at a time; a new start is taken in the cycle of the result.
// Reset restores tolerance 42950 and limit 32 and drops any item in work.
`default_nettype none

module newton_square_root_unit
    import nsr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [DATA_WIDTH-1:0] i_radicand,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_valid,
    output logic      [DATA_WIDTH-1:0] o_root,
    output logic      [LIMIT_W-1:0]    o_steps_taken,
    output logic      [STATUS_W-1:0]   o_finish_status
);

    localparam int SQ_W      = 2 * DATA_WIDTH;
    localparam int XS_W      = DATA_WIDTH + FRAC_BITS;
    localparam int MAG_WIDTH = (SQ_W > XS_W) ? SQ_W : XS_W;

    t_state                r_state, n_state;
    logic                  r_valid, n_valid;
    logic [TOL_W-1:0]      r_tol, n_tol;
    logic [LIMIT_W-1:0]    r_limit, n_limit;
    logic [DATA_WIDTH-1:0] r_t, n_t;
    logic [MAG_WIDTH-1:0]  r_xs, n_xs;
    logic [MAG_WIDTH-1:0]  r_mag, n_mag;
    logic                  r_pos, n_pos;
    logic [LIMIT_W-1:0]    r_steps, n_steps;
    logic [DATA_WIDTH-1:0] r_root, n_root;
    logic [LIMIT_W-1:0]    r_steps_out, n_steps_out;
    logic [STATUS_W-1:0]   r_status, n_status;

    logic                  accept;
    logic                  sq_start;
    t_unit_status          sq_sts;
    logic [MAG_WIDTH:0]    sq_diff;
    logic                  div_start;
    t_unit_status          div_sts;
    logic [DATA_WIDTH-1:0] div_quot;
    logic                  div_ovf;
    logic [DATA_WIDTH:0]   up_sum;
    logic [DATA_WIDTH-1:0] new_t;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign up_sum = {1'b0, r_t} + {1'b0, div_quot};

    always_comb begin
        if (r_pos) begin
            if (div_ovf || div_quot >= r_t) begin
                new_t = DATA_WIDTH'(1);
            end else begin
                new_t = r_t - div_quot;
            end
        end else begin
            if (div_ovf || up_sum[DATA_WIDTH]) begin
                new_t = '1;
            end else begin
                new_t = up_sum[DATA_WIDTH-1:0];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_tol       = r_tol;
        n_limit     = r_limit;
        n_t         = r_t;
        n_xs        = r_xs;
        n_mag       = r_mag;
        n_pos       = r_pos;
        n_steps     = r_steps;
        n_root      = r_root;
        n_steps_out = r_steps_out;
        n_status    = r_status;
        sq_start    = 1'b0;
        div_start   = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOLERANCE:  n_tol   = i_cfg_wdata[TOL_W-1:0];
                REG_ITER_LIMIT: n_limit = i_cfg_wdata[LIMIT_W-1:0];
                default:        n_tol   = r_tol;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_radicand == '0) begin
                        n_valid     = 1'b1;
                        n_root      = '0;
                        n_steps_out = '0;
                        n_status    = STS_TOLERANCE;
                    end else begin
                        n_xs    = MAG_WIDTH'(i_radicand) << FRAC_BITS;
                        n_t     = (i_radicand[DATA_WIDTH-1:1] == '0) ? DATA_WIDTH'(1)
                                                                    : i_radicand >> 1;
                        n_steps = '0;
                        sq_start = 1'b1;
                        n_state  = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE: begin
                if (sq_sts.done) begin
                    n_pos   = !sq_diff[MAG_WIDTH];
                    n_mag   = sq_diff[MAG_WIDTH] ? MAG_WIDTH'(~sq_diff + (MAG_WIDTH+1)'(1))
                                                 : sq_diff[MAG_WIDTH-1:0];
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_mag <= MAG_WIDTH'(r_tol)) begin
                    n_valid     = 1'b1;
                    n_root      = r_t;
                    n_steps_out = r_steps;
                    n_status    = STS_TOLERANCE;
                    n_state     = ST_IDLE;
                end else if (r_steps >= r_limit) begin
                    n_valid     = 1'b1;
                    n_root      = r_t;
                    n_steps_out = r_steps;
                    n_status    = STS_LIMIT;
                    n_state     = ST_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_sts.done) begin
                    n_steps = r_steps + LIMIT_W'(1);
                    if (new_t == r_t) begin
                        n_valid     = 1'b1;
                        n_root      = r_t;
                        n_steps_out = n_steps;
                        n_status    = STS_STALLED;
                        n_state     = ST_IDLE;
                    end else begin
                        n_t      = new_t;
                        sq_start = 1'b1;
                        n_state  = ST_SQUARE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_tol   <= TOL_RESET;
            r_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_tol   <= n_tol;
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t         <= n_t;
        r_xs        <= n_xs;
        r_mag       <= n_mag;
        r_pos       <= n_pos;
        r_steps     <= n_steps;
        r_root      <= n_root;
        r_steps_out <= n_steps_out;
        r_status    <= n_status;
    end

    nsr_square #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAG_WIDTH  (MAG_WIDTH)
    ) u_square (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (sq_start),
        .i_base   (n_t),
        .i_offset (n_xs),
        .o_status (sq_sts),
        .o_diff   (sq_diff)
    );

    nsr_divider #(
        .DATA_WIDTH (DATA_WIDTH),
        .MAG_WIDTH  (MAG_WIDTH)
    ) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_mag),
        .i_den    ({r_t, 1'b0}),
        .o_status (div_sts),
        .o_quot   (div_quot),
        .o_ovf    (div_ovf)
    );

    assign o_valid         = r_valid;
    assign o_root          = r_root;
    assign o_steps_taken   = r_steps_out;
    assign o_finish_status = r_status;

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a transfer is still in work");

    a_units_quiet_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!sq_sts.busy && !div_sts.busy))
        else $error("arithmetic unit running while the sequencer is idle");

    a_limit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finish_status == STS_LIMIT) |-> (o_steps_taken == r_limit))
        else $error("limit status without the full step count");

    a_zero_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_radicand == '0) |=> (o_valid && o_root == '0 && o_steps_taken == '0))
        else $error("zero radicand did not answer zero at once");

endmodule

`default_nettype wire

>>> rtl/nsr_square.sv
// Serial shift-add squarer that returns base*base minus an offset.
`default_nettype none

module nsr_square
    import nsr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAG_WIDTH  = 2 * DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DATA_WIDTH-1:0] i_base,
    input  wire logic [MAG_WIDTH-1:0]  i_offset,
    output t_unit_status               o_status,
    output logic      [MAG_WIDTH:0]    o_diff
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [MAG_WIDTH:0]    r_acc, n_acc;
    logic [MAG_WIDTH-1:0]  r_mcand, n_mcand;
    logic [DATA_WIDTH-1:0] r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_start) begin
            n_busy   = 1'b1;
            n_acc    = ~{1'b0, i_offset} + (MAG_WIDTH+1)'(1);
            n_mcand  = MAG_WIDTH'(i_base);
            n_mplier = i_base;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + {1'b0, r_mcand};
            end
            n_mcand  = r_mcand << 1;
            n_mplier = r_mplier >> 1;
            if (n_mplier == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_diff        = r_acc;

endmodule

`default_nettype wire

>>> rtl/nsr_divider.sv
// Serial restoring divider with an up-front quotient overflow check.
`default_nettype none

module nsr_divider
    import nsr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int MAG_WIDTH  = 2 * DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [MAG_WIDTH-1:0]  i_num,
    input  wire logic [DATA_WIDTH:0]   i_den,
    output t_unit_status               o_status,
    output logic      [DATA_WIDTH-1:0] o_quot,
    output logic                       o_ovf
);

    localparam int HI_W  = MAG_WIDTH - DATA_WIDTH;
    localparam int CMP_W = (HI_W > DATA_WIDTH + 1) ? HI_W : DATA_WIDTH + 1;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic                  r_ovf, n_ovf;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_WIDTH:0]   r_rem, n_rem;
    logic [DATA_WIDTH:0]   r_den, n_den;
    logic [DATA_WIDTH-1:0] r_low, n_low;
    logic [DATA_WIDTH-1:0] r_quot, n_quot;
    logic [HI_W-1:0]       num_hi;
    logic [DATA_WIDTH+1:0] trial;

    assign num_hi = i_num[MAG_WIDTH-1:DATA_WIDTH];
    assign trial  = {r_rem, r_low[DATA_WIDTH-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_quot = r_quot;
        if (i_start) begin
            n_ovf  = CMP_W'(num_hi) >= CMP_W'(i_den);
            n_rem  = (DATA_WIDTH+1)'(num_hi);
            n_den  = i_den;
            n_low  = i_num[DATA_WIDTH-1:0];
            n_quot = '0;
            n_cnt  = CNT_W'(DATA_WIDTH - 1);
            if (n_ovf) begin
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem  = (DATA_WIDTH+1)'(trial - {1'b0, r_den});
                n_quot = {r_quot[DATA_WIDTH-2:0], 1'b1};
            end else begin
                n_rem  = trial[DATA_WIDTH:0];
                n_quot = {r_quot[DATA_WIDTH-2:0], 1'b0};
            end
            n_low = r_low << 1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf  <= n_ovf;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;
    assign o_ovf         = r_ovf;

endmodule

`default_nettype wire

>>> verif/nsr_result_checker.sv
// Result checker for the Newton square root unit: predicts each root and compares on transfer.
`timescale 1ns / 100ps

module nsr_result_checker
    import nsr_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [DW-1:0]         i_radicand,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_valid,
    input  wire logic [DW-1:0]         i_root,
    input  wire logic [LIMIT_W-1:0]    i_steps_taken,
    input  wire logic [STATUS_W-1:0]   i_finish_status,
    output int                         o_outstanding,
    output int                         o_errors
);

    typedef struct packed {
        logic [DW-1:0]       root;
        logic [LIMIT_W-1:0]  steps;
        logic [STATUS_W-1:0] status;
    } sqrt_result_t;

    logic [TOL_W-1:0]   tol_copy;
    logic [LIMIT_W-1:0] limit_copy;
    sqrt_result_t       roots_due[$];
    int                 mismatch_count = 0;

    assign o_outstanding = roots_due.size();
    assign o_errors      = mismatch_count;

    function automatic sqrt_result_t predict_root(input logic [DW-1:0] x,
                                                  input logic [TOL_W-1:0] tol,
                                                  input logic [LIMIT_W-1:0] lim);
        logic [127:0]        est;
        logic [127:0]        next_est;
        logic [127:0]        square;
        logic [127:0]        target;
        logic [127:0]        resid;
        logic [127:0]        quot;
        logic [127:0]        top_val;
        bit                  above;
        bit                  ovf;
        bit                  done;
        int                  steps;
        logic [STATUS_W-1:0] status;
        sqrt_result_t        res;
        top_val = (128'd1 << DW) - 128'd1;
        if (x == '0) begin
            res.root   = '0;
            res.steps  = '0;
            res.status = STS_TOLERANCE;
            return res;
        end
        target = 128'(x) << FB;
        est    = 128'(x) >> 1;
        if (est == '0) begin
            est = 128'd1;
        end
        steps  = 0;
        done   = 1'b0;
        status = STS_TOLERANCE;
        while (!done) begin
            square = est * est;
            above  = (square >= target);
            resid  = above ? square - target : target - square;
            if (resid[127:64] == '0 && resid[63:0] <= 64'(tol)) begin
                status = STS_TOLERANCE;
                done   = 1'b1;
            end else if (steps >= int'(lim)) begin
                status = STS_LIMIT;
                done   = 1'b1;
            end else begin
                quot = resid / (est << 1);
                ovf  = (quot[127:64] != '0);
                if (above) begin
                    next_est = (ovf || quot >= est) ? 128'd1 : est - quot;
                end else begin
                    next_est = (ovf || quot > top_val - est) ? top_val : est + quot;
                end
                steps++;
                if (next_est == est) begin
                    status = STS_STALLED;
                    done   = 1'b1;
                end
                est = next_est;
            end
        end
        res.root   = est[DW-1:0];
        res.steps  = steps[LIMIT_W-1:0];
        res.status = status;
        return res;
    endfunction

    always @(posedge i_clk) begin
        sqrt_result_t want;
        if (!i_rst_n) begin
            tol_copy   = TOL_RESET;
            limit_copy = LIMIT_RESET;
            roots_due.delete();
        end else begin
            if (i_valid) begin
                if (roots_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual root %h steps %0d status %0d",
                             $time, i_root, i_steps_taken, i_finish_status);
                    mismatch_count++;
                end else begin
                    want = roots_due.pop_front();
                    if (i_root !== want.root) begin
                        $display("%0t: root mismatch, expected %h, actual %h",
                                 $time, want.root, i_root);
                        mismatch_count++;
                    end
                    if (i_steps_taken !== want.steps) begin
                        $display("%0t: steps_taken mismatch, expected %0d, actual %0d",
                                 $time, want.steps, i_steps_taken);
                        mismatch_count++;
                    end
                    if (i_finish_status !== want.status) begin
                        $display("%0t: finish_status mismatch, expected %0d, actual %0d",
                                 $time, want.status, i_finish_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TOLERANCE: begin
                        tol_copy = i_cfg_wdata[TOL_W-1:0];
                    end
                    REG_ITER_LIMIT: begin
                        limit_copy = i_cfg_wdata[LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                roots_due.push_back(predict_root(i_radicand, tol_copy, limit_copy));
            end
        end
    end

endmodule

>>> verif/newton_square_root_unit_tb.sv
// Testbench top for the Newton square root unit: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module newton_square_root_unit_tb;
    import nsr_pkg::*;

    localparam int DW           = DATA_WIDTH_DEF;
    localparam int FB           = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 30_000_000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 250;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [DW-1:0]         radicand = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  busy;
    logic                  o_valid;
    logic [DW-1:0]         o_root;
    logic [LIMIT_W-1:0]    o_steps_taken;
    logic [STATUS_W-1:0]   o_finish_status;
    int                    outstanding;
    int                    errors;
    int                    cycle_count = 0;

    logic [DW-1:0] base_vals [13] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0004_0000,
        32'hFFFE_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF,
        32'h0000_0100
    };
    logic [DW-1:0] nolimit_vals [4] = '{
        32'h0000_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_FFFF
    };
    logic [DW-1:0] onestep_vals [3] = '{
        32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000
    };
    logic [DW-1:0] exact_vals [4] = '{
        32'h0000_0002, 32'h0001_0000, 32'h1234_5678, 32'hFFFF_FFFF
    };

    always #10 i_clk = ~i_clk;

    newton_square_root_unit #(
        .DATA_WIDTH (DW),
        .FRAC_BITS  (FB)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_radicand      (radicand),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .o_valid         (o_valid),
        .o_root          (o_root),
        .o_steps_taken   (o_steps_taken),
        .o_finish_status (o_finish_status)
    );

    nsr_result_checker #(
        .DW (DW),
        .FB (FB)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_radicand      (radicand),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_valid         (o_valid),
        .i_root          (o_root),
        .i_steps_taken   (o_steps_taken),
        .i_finish_status (o_finish_status),
        .o_outstanding   (outstanding),
        .o_errors        (errors)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("newton_square_root_unit_tb: FAIL");
            $finish;
        end
    end

    // hold start until the transfer edge, return at the following falling edge
    task automatic send_radicand(input logic [DW-1:0] value);
        start    <= 1'b1;
        radicand <= value;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0 || busy);
    endtask

    task automatic set_config(input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] lim);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_TOLERANCE;
        cfg_wdata <= tol;
        @(negedge i_clk);
        cfg_idx   <= REG_ITER_LIMIT;
        cfg_wdata <= ($urandom & ~32'h3F) | CFG_DATA_W'(lim);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        @(negedge i_clk);
    endtask

    function automatic logic [DW-1:0] pick_radicand();
        logic [15:0] k;
        int          sel;
        k   = 16'($urandom);
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return '0;
            1, 2:    return $urandom >> $urandom_range(0, 31);
            3, 4:    return 32'(k) * 32'(k);
            5:       return 32'(k) * 32'(k) + 32'($urandom_range(0, 511)) - 32'd256;
            6:       return 32'h1 << $urandom_range(0, 31);
            7:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            return $urandom_range(1, 6);
        end else if (sel < 9) begin
            return $urandom_range(7, 80);
        end
        return $urandom_range(200, 1500);
    endfunction

    initial begin
        logic [TOL_W-1:0]   tol;
        logic [LIMIT_W-1:0] lim;
        int                 burst_left;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (base_vals[i]) begin
            send_radicand(base_vals[i]);
            idle_gap($urandom_range(0, 3));
        end
        wait_drained();
        set_config(TOL_RESET, 6'd0);
        foreach (nolimit_vals[i]) begin
            send_radicand(nolimit_vals[i]);
        end
        wait_drained();
        set_config(32'hFFFF_FFFF, 6'd1);
        foreach (onestep_vals[i]) begin
            send_radicand(onestep_vals[i]);
        end
        wait_drained();
        set_config(32'd0, 6'd63);
        foreach (exact_vals[i]) begin
            send_radicand(exact_vals[i]);
        end

        burst_left = $urandom_range(1, 24);
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            if (phase == 0) begin
                tol = TOL_RESET;
                lim = LIMIT_RESET;
            end else begin
                case ($urandom_range(0, 4))
                    0:       tol = '0;
                    1:       tol = $urandom_range(0, 1000);
                    2:       tol = 32'hFFFF_FFFF;
                    3:       tol = TOL_RESET + $urandom_range(0, 2000) - 1000;
                    default: tol = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0:       lim = 6'd1;
                    1:       lim = 6'd63;
                    2:       lim = LIMIT_W'($urandom_range(1, 8));
                    default: lim = LIMIT_W'($urandom_range(1, 63));
                endcase
            end
            set_config(tol, lim);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_radicand(pick_radicand());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    idle_gap(pick_gap());
                end
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("newton_square_root_unit_tb: PASS");
        end else begin
            $display("newton_square_root_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

>>> newton_square_root_unit.f
rtl/nsr_pkg.sv
rtl/nsr_square.sv
rtl/nsr_divider.sv
rtl/newton_square_root_unit.sv
verif/nsr_result_checker.sv
verif/newton_square_root_unit_tb.sv
